// File: rtl/ppbr_pkg.sv
`default_nettype none

package ppbr_pkg;

    // Widths fixed by the port signaling
    localparam int unsigned TIMER_W    = 16;
    localparam int unsigned IDLE_W     = 20;
    localparam int unsigned LIMIT_W    = 24;
    localparam int unsigned FLUSH_W    = 24;
    localparam int unsigned DATA_W     = 8;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 32;

    localparam int unsigned DEF_COUNT_BITS = 24;

    // Register reset values
    localparam logic [TIMER_W-1:0] BUSY_WAIT_RST    = TIMER_W'(5);
    localparam logic [TIMER_W-1:0] ACK_PULSE_RST    = TIMER_W'(2);
    localparam logic [IDLE_W-1:0]  IDLE_TIMEOUT_RST = IDLE_W'(500);
    localparam logic [LIMIT_W-1:0] CAPTURE_LIMIT_RST = LIMIT_W'(100 * 1024);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BUSY_WAIT     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_PULSE     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_LIMIT = CFG_IDX_W'(3);

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_BUSY = 3'b010,
        PH_ACK  = 3'b100
    } ppbr_phase_t;

    typedef struct packed {
        logic                busy_level;
        logic                ack_level;
        logic                byte_valid;
        logic [DATA_W-1:0]   byte_value;
        logic                byte_dropped;
        logic                flush_valid;
        logic [FLUSH_W-1:0]  flush_count;
    } ppbr_result_t;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } ppbr_cfg_wr_t;

endpackage

`default_nettype wire

// File: rtl/ppbr_core.sv
`default_nettype none

module ppbr_core import ppbr_pkg::*; #(
    parameter int unsigned COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ppbr_cfg_wr_t      cfg_wr,
    input  wire logic              step_en,
    input  wire logic              strobe_level,
    input  wire logic [DATA_W-1:0] data_byte,
    output ppbr_result_t           result
);

    localparam int unsigned CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [IDLE_W-1:0]     IDLE_MAX  = {IDLE_W{1'b1}};

    logic [TIMER_W-1:0]    busy_wait_reg;
    logic [TIMER_W-1:0]    ack_pulse_reg;
    logic [IDLE_W-1:0]     idle_timeout_reg;
    logic [LIMIT_W-1:0]    capture_limit_reg;

    ppbr_phase_t           phase_reg, phase_next;
    logic [TIMER_W-1:0]    timer_reg, timer_next;
    logic                  last_strobe_reg;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [IDLE_W-1:0]     idle_reg, idle_next;

    logic [TIMER_W-1:0]    timer_dec;
    logic [IDLE_W-1:0]     idle_inc;
    logic [CMP_W-1:0]      count_ext;
    logic [CMP_W-1:0]      limit_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_wait_reg     <= BUSY_WAIT_RST;
            ack_pulse_reg     <= ACK_PULSE_RST;
            idle_timeout_reg  <= IDLE_TIMEOUT_RST;
            capture_limit_reg <= CAPTURE_LIMIT_RST;
        end else if (cfg_wr.valid) begin
            unique case (cfg_wr.index)
                CFG_BUSY_WAIT:     busy_wait_reg     <= cfg_wr.data[TIMER_W-1:0];
                CFG_ACK_PULSE:     ack_pulse_reg     <= cfg_wr.data[TIMER_W-1:0];
                CFG_IDLE_TIMEOUT:  idle_timeout_reg  <= cfg_wr.data[IDLE_W-1:0];
                CFG_CAPTURE_LIMIT: capture_limit_reg <= cfg_wr.data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign timer_dec = (timer_reg != '0) ? timer_reg - TIMER_W'(1) : timer_reg;
    assign idle_inc  = (idle_reg != IDLE_MAX) ? idle_reg + IDLE_W'(1) : idle_reg;
    assign count_ext = CMP_W'(count_reg);
    assign limit_ext = CMP_W'(capture_limit_reg);

    always_comb begin
        logic [CMP_W-1:0] flush_ext;
        phase_next = phase_reg;
        timer_next = timer_reg;
        count_next = count_reg;
        idle_next  = idle_reg;
        flush_ext  = '0;
        result     = '0;

        unique case (phase_reg)
            PH_BUSY: begin
                timer_next = timer_dec;
            end
            PH_ACK: begin
                timer_next = timer_dec;
                if (timer_dec == '0) begin
                    phase_next = PH_IDLE;
                    idle_next  = '0;
                end
            end
            default: begin
                // unused codes fall back to idle
                phase_next = PH_IDLE;
                if (last_strobe_reg && !strobe_level) begin
                    phase_next = PH_BUSY;
                    timer_next = busy_wait_reg;
                end else begin
                    idle_next = idle_inc;
                    if (count_reg != '0 && idle_inc > idle_timeout_reg) begin
                        result.flush_valid = 1'b1;
                        flush_ext          = count_ext;
                        count_next         = '0;
                    end
                end
            end
        endcase

        // latch the data lines once the busy wait has run out
        if (phase_next == PH_BUSY && timer_next == '0) begin
            if (count_ext < limit_ext && count_reg != COUNT_MAX) begin
                result.byte_valid = 1'b1;
                result.byte_value = data_byte;
                count_next        = count_reg + COUNT_BITS'(1);
            end else begin
                result.byte_dropped = 1'b1;
            end
            phase_next = PH_ACK;
            timer_next = (ack_pulse_reg == '0) ? TIMER_W'(1) : ack_pulse_reg;
        end

        result.flush_count = flush_ext[FLUSH_W-1:0];
        result.busy_level  = (phase_next != PH_IDLE);
        result.ack_level   = (phase_next != PH_ACK);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            timer_reg       <= '0;
            last_strobe_reg <= 1'b1;
            count_reg       <= '0;
            idle_reg        <= '0;
        end else if (step_en) begin
            phase_reg       <= phase_next;
            timer_reg       <= timer_next;
            last_strobe_reg <= strobe_level;
            count_reg       <= count_next;
            idle_reg        <= idle_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/parallel_port_byte_receiver.sv
`default_nettype none

// Parallel port byte receiver, peripheral side of a printer port handshake.
// Each input transaction is one sampled tick of the strobe line and the eight
// data lines; each one yields exactly one result transaction carrying the busy
// and acknowledge line drives for that tick, an accepted or dropped byte, and
// a flush report when held bytes time out. A strobe falling edge seen while
// idle raises busy for busy_wait_ticks ticks, then the data byte of that tick
// is latched (accepted while the count is below capture_limit, else dropped),
// then ack goes low for ack_pulse_ticks ticks (0 acts as 1) and busy drops.
// Throughput is one transaction per clock while results are taken; a tick
// waits in the input register, then the tick update runs in a single
// combinational pass into the result register. While a finished result waits
// on m_ready the input register takes one more transaction, then s_ready
// stays low until the result is taken. Configuration is
// written through cfg_valid/cfg_index/cfg_data (always ready) and must only
// change while no transaction is in flight; unknown indexes are ignored.
module parallel_port_byte_receiver import ppbr_pkg::*; #(
    parameter int unsigned COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  s_valid,
    output      logic                  s_ready,
    input  wire logic                  s_strobe_level,
    input  wire logic [DATA_W-1:0]     s_data_byte,

    output      logic                  m_valid,
    input  wire logic                  m_ready,
    output      logic                  m_busy_level,
    output      logic                  m_ack_level,
    output      logic                  m_byte_valid,
    output      logic [DATA_W-1:0]     m_byte_value,
    output      logic                  m_byte_dropped,
    output      logic                  m_flush_valid,
    output      logic [FLUSH_W-1:0]    m_flush_count
);

    logic              in_valid_reg;
    logic              in_strobe_reg;
    logic [DATA_W-1:0] in_data_reg;

    logic              out_valid_reg;
    ppbr_result_t      out_reg;

    logic              advance;
    ppbr_cfg_wr_t      cfg_wr;
    ppbr_result_t      step_result;

    // Advance the held tick into the result register when that slot is free
    // or is being emptied this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    // Input register: hold the sampled tick until the core consumes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_strobe_reg <= s_strobe_level;
            in_data_reg   <= s_data_byte;
        end
    end

    // Tick update: state machine, timers, byte count and config registers.
    ppbr_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr       (cfg_wr),
        .step_en      (advance),
        .strobe_level (in_strobe_reg),
        .data_byte    (in_data_reg),
        .result       (step_result)
    );

    // Result register: drop valid once taken, load on advance.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= step_result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_busy_level   = out_reg.busy_level;
    assign m_ack_level    = out_reg.ack_level;
    assign m_byte_valid   = out_reg.byte_valid;
    assign m_byte_value   = out_reg.byte_value;
    assign m_byte_dropped = out_reg.byte_dropped;
    assign m_flush_valid  = out_reg.flush_valid;
    assign m_flush_count  = out_reg.flush_count;

endmodule

`default_nettype wire

// File: bench/port_tick_checker.sv
`timescale 1ns / 100ps

// Watches the configuration, tick and result channels of the parallel port
// receiver. Every accepted tick is run through a local model of the port
// handshake, and every accepted result is compared with the oldest prediction.
module port_tick_checker import ppbr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_strobe_level,
    input  logic [DATA_W-1:0]     s_data_byte,

    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_busy_level,
    input  logic                  m_ack_level,
    input  logic                  m_byte_valid,
    input  logic [DATA_W-1:0]     m_byte_value,
    input  logic                  m_byte_dropped,
    input  logic                  m_flush_valid,
    input  logic [FLUSH_W-1:0]    m_flush_count,

    output int                    mismatch_count,
    output int                    results_due
);

    localparam logic [DEF_COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [IDLE_W-1:0]         IDLE_SAT  = '1;

    logic [TIMER_W-1:0]        busy_wait_cfg;
    logic [TIMER_W-1:0]        ack_pulse_cfg;
    logic [IDLE_W-1:0]         idle_timeout_cfg;
    logic [LIMIT_W-1:0]        capture_limit_cfg;

    ppbr_phase_t               port_phase;
    logic [TIMER_W-1:0]        phase_timer;
    logic                      strobe_was_high;
    logic [DEF_COUNT_BITS-1:0] bytes_held;
    logic [IDLE_W-1:0]         idle_run;

    ppbr_result_t              line_states_due[$];

    // One sampled tick of the port lines: advance the handshake, return the
    // line drives and any byte or flush report of this tick.
    task automatic advance_port_tick(input logic strobe, input logic [DATA_W-1:0] data,
                                     output ppbr_result_t res);
        res = '0;
        case (port_phase)
            PH_BUSY: begin
                if (phase_timer != 0) phase_timer = phase_timer - 1'b1;
            end
            PH_ACK: begin
                if (phase_timer != 0) phase_timer = phase_timer - 1'b1;
                if (phase_timer == 0) begin
                    port_phase = PH_IDLE;
                    idle_run   = '0;
                end
            end
            default: begin
                port_phase = PH_IDLE;
                if (strobe_was_high && !strobe) begin
                    port_phase  = PH_BUSY;
                    phase_timer = busy_wait_cfg;
                end else begin
                    if (idle_run != IDLE_SAT) idle_run = idle_run + 1'b1;
                    // flush only when the idle run strictly exceeds the timeout
                    if (bytes_held != 0 && idle_run > idle_timeout_cfg) begin
                        res.flush_valid = 1'b1;
                        res.flush_count = bytes_held;
                        bytes_held      = '0;
                    end
                end
            end
        endcase

        // latch on the tick the busy wait runs out, the edge tick itself for a zero wait
        if (port_phase == PH_BUSY && phase_timer == 0) begin
            if (bytes_held < capture_limit_cfg && bytes_held != COUNT_MAX) begin
                res.byte_valid = 1'b1;
                res.byte_value = data;
                bytes_held     = bytes_held + 1'b1;
            end else begin
                res.byte_dropped = 1'b1;
            end
            port_phase  = PH_ACK;
            phase_timer = (ack_pulse_cfg == 0) ? TIMER_W'(1) : ack_pulse_cfg;
        end

        strobe_was_high = strobe;
        res.busy_level  = (port_phase != PH_IDLE);
        res.ack_level   = (port_phase != PH_ACK);
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch_channels
        ppbr_result_t predicted;
        ppbr_result_t want;
        if (!aresetn) begin
            busy_wait_cfg     = BUSY_WAIT_RST;
            ack_pulse_cfg     = ACK_PULSE_RST;
            idle_timeout_cfg  = IDLE_TIMEOUT_RST;
            capture_limit_cfg = CAPTURE_LIMIT_RST;
            port_phase        = PH_IDLE;
            phase_timer       = '0;
            strobe_was_high   = 1'b1;
            bytes_held        = '0;
            idle_run          = '0;
            mismatch_count    = 0;
            line_states_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_BUSY_WAIT:     busy_wait_cfg     = cfg_data[TIMER_W-1:0];
                    CFG_ACK_PULSE:     ack_pulse_cfg     = cfg_data[TIMER_W-1:0];
                    CFG_IDLE_TIMEOUT:  idle_timeout_cfg  = cfg_data[IDLE_W-1:0];
                    CFG_CAPTURE_LIMIT: capture_limit_cfg = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                advance_port_tick(s_strobe_level, s_data_byte, predicted);
                line_states_due.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                if (line_states_due.size() == 0) begin
                    check_field("result with nothing due, busy_level", 32'd0, 32'd1);
                end else begin
                    want = line_states_due.pop_front();
                    check_field("busy_level",   want.busy_level,   m_busy_level);
                    check_field("ack_level",    want.ack_level,    m_ack_level);
                    check_field("byte_valid",   want.byte_valid,   m_byte_valid);
                    check_field("byte_value",   want.byte_value,   m_byte_value);
                    check_field("byte_dropped", want.byte_dropped, m_byte_dropped);
                    check_field("flush_valid",  want.flush_valid,  m_flush_valid);
                    check_field("flush_count",  want.flush_count,  m_flush_count);
                end
            end
        end
        results_due <= line_states_due.size();
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

// Top of the parallel port receiver bench: drives the tick, configuration and
// result channels and gives the verdict. All prediction and comparison lives
// in port_tick_checker.
module tb_top;
    import ppbr_pkg::*;

    localparam int HOLD_OFF_CYCLES    = 300;
    localparam int FIRST_UNUSED_INDEX = 4;
    localparam int LAST_INDEX         = (1 << CFG_IDX_W) - 1;

    logic                  aclk;
    logic                  aresetn;

    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic                  s_valid;
    logic                  s_ready;
    logic                  s_strobe_level;
    logic [DATA_W-1:0]     s_data_byte;

    logic                  m_valid;
    logic                  m_ready;
    logic                  m_busy_level;
    logic                  m_ack_level;
    logic                  m_byte_valid;
    logic [DATA_W-1:0]     m_byte_value;
    logic                  m_byte_dropped;
    logic                  m_flush_valid;
    logic [FLUSH_W-1:0]    m_flush_count;

    int mismatch_count;
    int results_due;

    // idle percentages of the two sides, in cycles per hundred
    int src_idle_pct = 16;
    int snk_idle_pct = 59;

    int hold_offs_requested = 0;
    int hold_offs_done      = 0;

    // settings last given to the block, used to size the tick sequences
    int busy_wait_set    = 5;
    int ack_pulse_set    = 2;
    int idle_timeout_set = 500;

    parallel_port_byte_receiver DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_strobe_level (s_strobe_level),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_busy_level   (m_busy_level),
        .m_ack_level    (m_ack_level),
        .m_byte_valid   (m_byte_valid),
        .m_byte_value   (m_byte_value),
        .m_byte_dropped (m_byte_dropped),
        .m_flush_valid  (m_flush_valid),
        .m_flush_count  (m_flush_count)
    );

    port_tick_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_strobe_level (s_strobe_level),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_busy_level   (m_busy_level),
        .m_ack_level    (m_ack_level),
        .m_byte_valid   (m_byte_valid),
        .m_byte_value   (m_byte_value),
        .m_byte_dropped (m_byte_dropped),
        .m_flush_valid  (m_flush_valid),
        .m_flush_count  (m_flush_count),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: random back-pressure, plus a long hold-off whenever the
    // stimulus asks for one, so the block fills up and stalls its input.
    initial begin : result_sink
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_offs_done < hold_offs_requested) begin
                hold_offs_done++;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(1, 100) > snk_idle_pct);
        end
    end

    // Offer one port tick as a transaction and hold it until accepted.
    // Entered and left right after a rising edge.
    task automatic send_tick(input logic strobe, input logic [DATA_W-1:0] data);
        while ($urandom_range(1, 100) <= src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_strobe_level <= strobe;
        s_data_byte    <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stop offering ticks until every predicted result has come back.
    task automatic wait_all_results;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Leave valid high; the caller drops it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Drain, then write all four registers with junk above each register's
    // width, plus one write to an index that does not exist.
    task automatic set_config(input int busy, input int ack, input int tmo, input int lim);
        logic [31:0]          junk;
        logic [CFG_IDX_W-1:0] bad_idx;
        wait_all_results();
        junk = $urandom;
        write_reg(CFG_BUSY_WAIT, {junk[31:16], busy[15:0]});
        junk = $urandom;
        write_reg(CFG_ACK_PULSE, {junk[31:16], ack[15:0]});
        junk = $urandom;
        write_reg(CFG_IDLE_TIMEOUT, {junk[31:20], tmo[19:0]});
        junk = $urandom;
        write_reg(CFG_CAPTURE_LIMIT, {junk[31:24], lim[23:0]});
        junk    = $urandom;
        bad_idx = CFG_IDX_W'($urandom_range(FIRST_UNUSED_INDEX, LAST_INDEX));
        write_reg(bad_idx, junk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        busy_wait_set    = busy;
        ack_pulse_set    = ack;
        idle_timeout_set = tmo;
    endtask

    // Mostly well-formed strobe pulses with the byte held through the busy
    // wait; the rest idle gaps (to reach the flush) and random line noise.
    task automatic run_traffic(input int n_ticks);
        int sent;
        int kind;
        int hi_n;
        int lo_n;
        int hold_n;
        int gap_max;
        logic [DATA_W-1:0] d;
        sent = 0;
        while (sent < n_ticks) begin
            kind = $urandom_range(0, 9);
            d    = DATA_W'($urandom);
            if (kind <= 6) begin
                hi_n   = $urandom_range(1, 3);
                lo_n   = $urandom_range(1, 4);
                hold_n = $urandom_range(0, busy_wait_set + ack_pulse_set + 2);
                repeat (hi_n) send_tick(1'b1, d);
                repeat (lo_n) send_tick(1'b0, d);
                repeat (hold_n) send_tick(1'b1, d);
                sent += hi_n + lo_n + hold_n;
            end else if (kind == 7) begin
                gap_max = idle_timeout_set + 4;
                if (gap_max > 40) gap_max = 40;
                hold_n = $urandom_range(1, gap_max);
                repeat (hold_n) send_tick(1'b1, DATA_W'($urandom));
                sent += hold_n;
            end else begin
                hold_n = $urandom_range(1, 8);
                repeat (hold_n) send_tick(1'($urandom), DATA_W'($urandom));
                sent += hold_n;
            end
        end
    endtask

    // One handshake with a long busy wait and ack pulse; the strobe
    // toggles early on and must be ignored until the block is idle again.
    task automatic long_handshake;
        int n;
        send_tick(1'b1, DATA_W'($urandom));
        send_tick(1'b0, DATA_W'($urandom));
        for (n = 0; n < busy_wait_set + ack_pulse_set + 4; n++)
            send_tick((n < 20) ? n[0] : 1'b1, DATA_W'($urandom));
        repeat (idle_timeout_set + 3) send_tick(1'b1, DATA_W'($urandom));
    endtask

    initial begin : stimulus
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_strobe_level = 1'b1;
        s_data_byte    = '0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: busy wait of five, ack of two; a second falling edge
        // during busy and a low strobe during ack are both ignored.
        send_tick(1'b1, 8'h00);
        send_tick(1'b0, 8'hFF);
        send_tick(1'b0, 8'hFF);
        send_tick(1'b1, 8'hFF);
        send_tick(1'b0, 8'hFF);
        send_tick(1'b1, 8'hFF);
        send_tick(1'b1, 8'hFF);
        send_tick(1'b0, 8'h00);
        send_tick(1'b1, 8'h00);

        // Zero busy wait latches on the edge tick, zero ack acts as one tick; two
        // bytes reach a limit of two, the idle run flushes them, and the next byte too.
        set_config(0, 0, 2, 2);
        send_tick(1'b0, 8'h00);
        send_tick(1'b1, 8'h5A);
        send_tick(1'b0, 8'hA5);
        send_tick(1'b1, 8'h3C);
        repeat (3) send_tick(1'b1, 8'hC3);
        send_tick(1'b0, 8'h80);
        send_tick(1'b1, 8'h01);
        repeat (3) send_tick(1'b1, 8'h7F);

        // Sender idles little, receiver a lot; one long result hold-off.
        set_config(0, 1, 5, 3);
        hold_offs_requested++;
        run_traffic(80);
        set_config(3, 0, 0, 16777215);
        run_traffic(80);

        // Now the other way round.
        src_idle_pct = 59;
        snk_idle_pct = 16;
        set_config(1, 4, 12, 1);
        run_traffic(80);
        set_config(2, 2, 1048575, $urandom_range(1, 40));
        run_traffic(80);

        // No idling on either side.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_config($urandom_range(0, 6), $urandom_range(0, 6),
                   $urandom_range(0, 20), $urandom_range(1, 8));
        hold_offs_requested++;
        run_traffic(80);
        set_config(45, 45, 3, 16777215);
        long_handshake();
        set_config($urandom_range(0, 6), $urandom_range(0, 6),
                   $urandom_range(0, 20), $urandom_range(1, 8));
        run_traffic(80);

        wait_all_results();
        if (mismatch_count == 0 && results_due == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Guard against a hang: several times the slowest legal run.
    initial begin : run_limit
        #6_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
rtl/ppbr_pkg.sv
rtl/ppbr_core.sv
rtl/parallel_port_byte_receiver.sv
bench/port_tick_checker.sv
bench/tb_top.sv
